@@ rtl/mpas_pkg.sv @@
// Shared types and constants of the multilevel priority aging scheduler.
// No dependencies; used by mpas_ctrl, mpas_dp and the top level.
package mpas_pkg;

    typedef enum logic [2:0] {
        ST_ADDED      = 3'd0,
        ST_BAD_PRIO   = 3'd1,
        ST_FULL       = 3'd2,
        ST_DISPATCHED = 3'd3,
        ST_IDLE       = 3'd4
    } status_t;

    typedef enum logic {
        CFG_QUANTUM = 1'b0,
        CFG_AGING   = 1'b1
    } cfg_idx_t;

    localparam logic [7:0]  QUANTUM_RST = 8'd3;
    localparam logic [15:0] AGING_RST   = 16'd1;
    localparam logic [3:0]  FIRST_AGED_LEVEL = 4'd2;

    typedef struct packed {
        logic [7:0]  task_id;
        logic [3:0]  level;
        logic [15:0] remaining;
        logic [31:0] stamp;
        logic [31:0] order;
    } slot_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_ADD,
        S_PICK,
        S_PICK_END,
        S_RUN,
        S_AGE,
        S_AGE_END,
        S_FINISH,
        S_DONE
    } state_t;

    typedef struct packed {
        logic    capture;
        logic    add_step;
        logic    scan_step;
        logic    scan_age;
        logic    run_apply;
        logic    age_apply;
        logic    lv_inc;
        logic    finish;
        logic    set_status;
        status_t status_code;
        logic    load_out;
    } cmd_t;

    typedef struct packed {
        logic is_dispatch;
        logic prio_ok;
        logic add_free;
        logic scan_end;
        logic found;
        logic lv_last;
        logic out_free;
    } stat_t;

endpackage

@@ rtl/mpas_ctrl.sv @@
// Sequencer of the scheduler: walks add, pick, run and aging phases.
// Depends on mpas_pkg; drives mpas_dp through cmd_t, reads stat_t.
module mpas_ctrl
    import mpas_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_DECODE;
            end
            S_DECODE:
            begin
                if (stat.is_dispatch)
                    state_next = S_PICK;
                else if (stat.prio_ok)
                    state_next = S_ADD;
                else
                    state_next = S_DONE;
            end
            S_ADD:
            begin
                if (stat.add_free || stat.scan_end)
                    state_next = S_DONE;
            end
            S_PICK:
            begin
                if (stat.scan_end)
                    state_next = S_PICK_END;
            end
            S_PICK_END:
            begin
                state_next = stat.found ? S_RUN : S_DONE;
            end
            S_RUN:
            begin
                state_next = S_AGE;
            end
            S_AGE:
            begin
                if (stat.scan_end)
                    state_next = S_AGE_END;
            end
            S_AGE_END:
            begin
                if (stat.found || !stat.lv_last)
                    state_next = S_AGE;
                else
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.status_code = ST_ADDED;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.capture = in_valid;
            end
            S_DECODE:
            begin
                if (!stat.is_dispatch && !stat.prio_ok)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_BAD_PRIO;
                end
            end
            S_ADD:
            begin
                cmd.add_step = 1'b1;
                if (stat.add_free)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_ADDED;
                end
                else if (stat.scan_end)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_FULL;
                end
            end
            S_PICK:
            begin
                cmd.scan_step = 1'b1;
            end
            S_PICK_END:
            begin
                if (!stat.found)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_IDLE;
                end
            end
            S_RUN:
            begin
                cmd.run_apply = 1'b1;
            end
            S_AGE:
            begin
                cmd.scan_step = 1'b1;
                cmd.scan_age  = 1'b1;
            end
            S_AGE_END:
            begin
                if (stat.found)
                    cmd.age_apply = 1'b1;
                else if (!stat.lv_last)
                    cmd.lv_inc = 1'b1;
            end
            S_FINISH:
            begin
                cmd.finish      = 1'b1;
                cmd.set_status  = 1'b1;
                cmd.status_code = ST_DISPATCHED;
            end
            S_DONE:
            begin
                cmd.load_out = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

@@ rtl/mpas_dp.sv @@
// Datapath of the scheduler: slot memory, valid/seen maps, scan unit,
// clock and order counters, config registers, result and output regs.
// Depends on mpas_pkg; controlled by mpas_ctrl.
module mpas_dp
    import mpas_pkg::*;
#(
    parameter int LEVELS = 10,
    parameter int SLOTS  = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output stat_t       stat,
    input  logic        req_type,
    input  logic [7:0]  task_id,
    input  logic [3:0]  priority_req,
    input  logic [15:0] burst,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [7:0]  run_id,
    output logic [3:0]  run_level,
    output logic [7:0]  ticks_run,
    output logic [15:0] burst_left,
    output logic        finished,
    output logic [6:0]  aged_count,
    output logic [31:0] time_now
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [CW-1:0] SCAN_END = CW'(SLOTS);
    localparam logic [3:0]    LV_TOP   = 4'(LEVELS);
    localparam logic [SLOTS-1:0] ONE_HOT0 = {{(SLOTS-1){1'b0}}, 1'b1};

    // slot memory, one write and one registered read port
    slot_t          mem [SLOTS];
    slot_t          rd_data_reg;
    logic           mem_we;
    logic [IW-1:0]  mem_wa;
    slot_t          mem_wd;

    logic [SLOTS-1:0] valid_reg;
    logic [SLOTS-1:0] seen_reg;

    logic [CW-1:0]  scan_cnt_reg;
    logic [IW-1:0]  rd_addr;
    logic           pend_vld_reg;
    logic [IW-1:0]  pend_idx_reg;
    logic           found_reg;
    logic [IW-1:0]  best_idx_reg;
    slot_t          best_reg;
    logic [31:0]    best_age_reg;
    logic [3:0]     lv_reg;
    logic [31:0]    clock_reg;
    logic [31:0]    oc_reg;
    logic [7:0]     quantum_reg;
    logic [15:0]    thr_reg;

    logic           req_type_reg;
    logic [7:0]     req_id_reg;
    logic [3:0]     req_prio_reg;
    logic [15:0]    req_burst_reg;

    status_t        res_status_reg;
    logic [7:0]     res_id_reg;
    logic [3:0]     res_level_reg;
    logic [7:0]     res_ticks_reg;
    logic [15:0]    res_left_reg;
    logic           res_fin_reg;
    logic [6:0]     res_aged_reg;
    logic [IW-1:0]  run_idx_reg;

    logic           out_valid_reg;
    status_t        out_status_reg;
    logic [7:0]     out_id_reg;
    logic [3:0]     out_level_reg;
    logic [7:0]     out_ticks_reg;
    logic [15:0]    out_left_reg;
    logic           out_fin_reg;
    logic [6:0]     out_aged_reg;
    logic [31:0]    out_time_reg;

    logic           scan_end;
    logic           add_free;
    logic [31:0]    cand_age;
    logic           cand_ok;
    logic           cand_better;
    logic           take;
    logic [7:0]     ticks_w;
    logic [31:0]    clock_run;
    logic [15:0]    left_w;
    logic [31:0]    wait_w;
    logic           promote;
    logic           scan_clr;
    logic           out_free;

    assign rd_addr  = scan_cnt_reg[IW-1:0];
    assign scan_end = (scan_cnt_reg == SCAN_END);
    assign add_free = !scan_end && !valid_reg[rd_addr];

    // candidate compare: age grows toward the head of a level
    assign cand_age = oc_reg - rd_data_reg.order;

    always_comb
    begin
        if (cmd.scan_age)
        begin
            cand_ok = valid_reg[pend_idx_reg] && !seen_reg[pend_idx_reg]
                      && (rd_data_reg.level == lv_reg);
            cand_better = !found_reg || (cand_age > best_age_reg);
        end
        else
        begin
            cand_ok = valid_reg[pend_idx_reg];
            cand_better = !found_reg || (rd_data_reg.level < best_reg.level)
                          || ((rd_data_reg.level == best_reg.level)
                              && (cand_age > best_age_reg));
        end
    end

    assign take = cmd.scan_step && pend_vld_reg && cand_ok && cand_better;

    assign ticks_w   = (best_reg.remaining < {8'd0, quantum_reg})
                       ? best_reg.remaining[7:0] : quantum_reg;
    assign clock_run = clock_reg + {24'd0, ticks_w};
    assign left_w    = best_reg.remaining - {8'd0, ticks_w};
    assign wait_w    = clock_reg - best_reg.stamp;
    assign promote   = (wait_w >= {16'd0, thr_reg});
    assign scan_clr  = cmd.capture || cmd.run_apply || cmd.age_apply || cmd.lv_inc;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = best_idx_reg;
        mem_wd = best_reg;
        if (cmd.add_step && add_free)
        begin
            mem_we           = 1'b1;
            mem_wa           = rd_addr;
            mem_wd.task_id   = req_id_reg;
            mem_wd.level     = req_prio_reg;
            mem_wd.remaining = req_burst_reg;
            mem_wd.stamp     = clock_reg;
            mem_wd.order     = oc_reg;
        end
        else if (cmd.run_apply)
        begin
            mem_we           = 1'b1;
            mem_wd.remaining = left_w;
            mem_wd.stamp     = clock_run;
        end
        else if (cmd.age_apply && promote)
        begin
            mem_we       = 1'b1;
            mem_wd.level = lv_reg - 4'd1;
            mem_wd.stamp = clock_reg;
            mem_wd.order = oc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        rd_data_reg <= mem[rd_addr];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            seen_reg      <= '0;
            scan_cnt_reg  <= '0;
            pend_vld_reg  <= 1'b0;
            pend_idx_reg  <= '0;
            found_reg     <= 1'b0;
            lv_reg        <= FIRST_AGED_LEVEL;
            clock_reg     <= '0;
            oc_reg        <= '0;
            quantum_reg   <= QUANTUM_RST;
            thr_reg       <= AGING_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_QUANTUM: quantum_reg <= cfg_data[7:0];
                    CFG_AGING:   thr_reg     <= cfg_data;
                    default:     ;
                endcase
            end

            if (scan_clr)
            begin
                scan_cnt_reg <= '0;
                pend_vld_reg <= 1'b0;
                found_reg    <= 1'b0;
            end
            else if (cmd.scan_step || cmd.add_step)
            begin
                if (!scan_end && !(cmd.add_step && add_free))
                    scan_cnt_reg <= scan_cnt_reg + 1'b1;
                pend_vld_reg <= cmd.scan_step && !scan_end;
                pend_idx_reg <= rd_addr;
                if (take)
                    found_reg <= 1'b1;
            end

            if (cmd.add_step && add_free)
            begin
                valid_reg[rd_addr] <= 1'b1;
                oc_reg             <= oc_reg + 32'd1;
            end

            // seen map restarts holding only the task just run
            if (cmd.run_apply)
            begin
                clock_reg <= clock_run;
                seen_reg  <= ONE_HOT0 << best_idx_reg;
                lv_reg    <= FIRST_AGED_LEVEL;
            end

            if (cmd.age_apply)
            begin
                seen_reg[best_idx_reg] <= 1'b1;
                if (promote)
                    oc_reg <= oc_reg + 32'd1;
            end

            if (cmd.lv_inc)
                lv_reg <= lv_reg + 4'd1;

            if (cmd.finish && (res_left_reg == 16'd0))
                valid_reg[run_idx_reg] <= 1'b0;

            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_type_reg  <= req_type;
            req_id_reg    <= task_id;
            req_prio_reg  <= priority_req;
            req_burst_reg <= burst;
            res_id_reg    <= '0;
            res_level_reg <= '0;
            res_ticks_reg <= '0;
            res_left_reg  <= '0;
            res_fin_reg   <= 1'b0;
            res_aged_reg  <= '0;
        end

        if (take)
        begin
            best_reg     <= rd_data_reg;
            best_idx_reg <= pend_idx_reg;
            best_age_reg <= cand_age;
        end

        if (cmd.set_status)
            res_status_reg <= cmd.status_code;

        if (cmd.run_apply)
        begin
            res_id_reg    <= best_reg.task_id;
            res_level_reg <= best_reg.level;
            res_ticks_reg <= ticks_w;
            res_left_reg  <= left_w;
            run_idx_reg   <= best_idx_reg;
        end

        if (cmd.age_apply && promote)
            res_aged_reg <= res_aged_reg + 7'd1;

        if (cmd.finish)
            res_fin_reg <= (res_left_reg == 16'd0);

        if (cmd.load_out)
        begin
            out_status_reg <= res_status_reg;
            out_id_reg     <= res_id_reg;
            out_level_reg  <= res_level_reg;
            out_ticks_reg  <= res_ticks_reg;
            out_left_reg   <= res_left_reg;
            out_fin_reg    <= res_fin_reg;
            out_aged_reg   <= res_aged_reg;
            out_time_reg   <= clock_reg;
        end
    end

    assign stat.is_dispatch = req_type_reg;
    assign stat.prio_ok     = (req_prio_reg != 4'd0) && (req_prio_reg <= LV_TOP);
    assign stat.add_free    = add_free;
    assign stat.scan_end    = scan_end;
    assign stat.found       = found_reg;
    assign stat.lv_last     = (lv_reg == LV_TOP);
    assign stat.out_free    = out_free;

    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign run_id     = out_id_reg;
    assign run_level  = out_level_reg;
    assign ticks_run  = out_ticks_reg;
    assign burst_left = out_left_reg;
    assign finished   = out_fin_reg;
    assign aged_count = out_aged_reg;
    assign time_now   = out_time_reg;

endmodule

@@ rtl/multilevel_priority_aging_scheduler_core.sv @@
// Top level of the multilevel priority aging scheduler.
// Depends on mpas_pkg, mpas_ctrl and mpas_dp.
//
//  channel  | handshake          | payload
//  ---------+--------------------+--------------------------------------------
//  request  | in_valid/in_stall  | req_type task_id priority_req burst
//  result   | out_valid/out_stall| status run_id run_level ticks_run
//           |                    | burst_left finished aged_count time_now
//  config   | cfg_we             | cfg_index cfg_data (0 quantum, 1 threshold)
//
// One request at a time; in_stall is high from the transfer until the
// result sits in the output register. A result may wait there while the
// next request is already taken.
// Add: one scan from slot 0 that passes over occupied slots (up to SLOTS).
// Dispatch: every pass walks the slot memory through its one read port;
// there is one pick pass, then one aging pass per task examined and one
// per level 2..LEVELS.
// Reset is asynchronous; the valid map clears at once, no clearing pass.
module multilevel_priority_aging_scheduler_core
    import mpas_pkg::*;
#(
    parameter int LEVELS = 10,
    parameter int SLOTS  = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [7:0]  task_id,
    input  logic [3:0]  priority_req,
    input  logic [15:0] burst,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [7:0]  run_id,
    output logic [3:0]  run_level,
    output logic [7:0]  ticks_run,
    output logic [15:0] burst_left,
    output logic        finished,
    output logic [6:0]  aged_count,
    output logic [31:0] time_now,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    // sequencer: owns the request handshake
    mpas_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // slot table, scan unit, counters and output register
    mpas_dp #(
        .LEVELS (LEVELS),
        .SLOTS  (SLOTS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .req_type     (req_type),
        .task_id      (task_id),
        .priority_req (priority_req),
        .burst        (burst),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .run_id       (run_id),
        .run_level    (run_level),
        .ticks_run    (ticks_run),
        .burst_left   (burst_left),
        .finished     (finished),
        .aged_count   (aged_count),
        .time_now     (time_now)
    );

    // a taken request keeps the block busy in the next cycle
    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request side not busy after transfer");

    // only a dispatch result carries run information
    a_non_dispatch_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_DISPATCHED) |->
            (run_id == 8'd0) && (ticks_run == 8'd0) && (aged_count == 7'd0)
            && !finished)
        else $error("run fields set on non-dispatch result");

    // a removed task has no burst left
    a_finished_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && finished |-> (burst_left == 16'd0))
        else $error("finished with burst left");

endmodule

@@ tb/mpas_checker.sv @@
`timescale 1ns / 100ps
// Scoreboard for the multilevel priority aging scheduler: watches the
// request, result and config ports, predicts each result and compares it.
// Depends on mpas_pkg.
module mpas_checker
    import mpas_pkg::*;
#(
    parameter int LEVELS = 10,
    parameter int SLOTS  = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        req_type,
    input  logic [7:0]  task_id,
    input  logic [3:0]  priority_req,
    input  logic [15:0] burst,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [2:0]  status,
    input  logic [7:0]  run_id,
    input  logic [3:0]  run_level,
    input  logic [7:0]  ticks_run,
    input  logic [15:0] burst_left,
    input  logic        finished,
    input  logic [6:0]  aged_count,
    input  logic [31:0] time_now,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    output int          errors,
    output int          pending,
    output int          live
);

    typedef struct packed {
        logic [2:0]  st;
        logic [7:0]  id;
        logic [3:0]  lvl;
        logic [7:0]  ticks;
        logic [15:0] left;
        logic        fin;
        logic [6:0]  aged;
        logic [31:0] now;
    } sched_result_t;

    sched_result_t result_q[$];

    logic [7:0]  quantum;
    logic [15:0] threshold;
    logic        occ[SLOTS];
    logic [7:0]  t_id[SLOTS];
    logic [3:0]  t_lvl[SLOTS];
    logic [15:0] t_rem[SLOTS];
    logic [31:0] t_stamp[SLOTS];
    logic [31:0] t_seq[SLOTS];
    logic [31:0] sim_clock;
    logic [31:0] seq_next;

    // oldest task at a level, ignoring slots marked in skip; -1 if none
    function automatic int oldest_at(int lv, logic [SLOTS-1:0] skip);
        int best;
        best = -1;
        for (int i = 0; i < SLOTS; i++) begin
            if (!occ[i] || t_lvl[i] != lv || skip[i])
                continue;
            if (best < 0 || (seq_next - t_seq[i]) > (seq_next - t_seq[best]))
                best = i;
        end
        return best;
    endfunction

    task automatic predict_request(input logic rq, input logic [7:0] id,
                                   input logic [3:0] pr, input logic [15:0] bu);
        sched_result_t r;
        int free_slot;
        int run;
        int t;
        logic [SLOTS-1:0] seen;
        logic [15:0] tk;
        r = '0;
        if (rq == 1'b0) begin
            if (pr < 1 || pr > LEVELS) begin
                r.st = ST_BAD_PRIO;
            end
            else begin
                free_slot = -1;
                for (int i = 0; i < SLOTS; i++)
                    if (!occ[i] && free_slot < 0)
                        free_slot = i;
                if (free_slot < 0) begin
                    r.st = ST_FULL;
                end
                else begin
                    occ[free_slot]     = 1'b1;
                    t_id[free_slot]    = id;
                    t_lvl[free_slot]   = pr;
                    t_rem[free_slot]   = bu;
                    t_stamp[free_slot] = sim_clock;
                    t_seq[free_slot]   = seq_next;
                    seq_next++;
                    live++;
                    r.st = ST_ADDED;
                end
            end
        end
        else begin
            run = -1;
            for (int lv = 1; lv <= LEVELS && run < 0; lv++)
                run = oldest_at(lv, '0);
            if (run < 0) begin
                r.st = ST_IDLE;
            end
            else begin
                r.st  = ST_DISPATCHED;
                r.id  = t_id[run];
                r.lvl = t_lvl[run];
                tk = (t_rem[run] < {8'd0, quantum}) ? t_rem[run] : {8'd0, quantum};
                sim_clock    += {16'd0, tk};
                t_rem[run]   = t_rem[run] - tk;
                t_stamp[run] = sim_clock;
                r.ticks = tk[7:0];
                r.left  = t_rem[run];
                seen = '0;
                seen[run] = 1'b1;
                // aging walk: level 2 upward, FIFO order, each task once
                for (int lv = FIRST_AGED_LEVEL; lv <= LEVELS; lv++) begin
                    t = oldest_at(lv, seen);
                    while (t >= 0) begin
                        seen[t] = 1'b1;
                        if ((sim_clock - t_stamp[t]) >= {16'd0, threshold}) begin
                            t_lvl[t]   = 4'(lv - 1);
                            t_stamp[t] = sim_clock;
                            t_seq[t]   = seq_next;
                            seq_next++;
                            r.aged++;
                        end
                        t = oldest_at(lv, seen);
                    end
                end
                if (r.left == 16'd0) begin
                    occ[run] = 1'b0;
                    r.fin = 1'b1;
                    live--;
                end
            end
        end
        r.now = sim_clock;
        result_q.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sched_result_t e;
        if (!rst_n) begin
            quantum   = QUANTUM_RST;
            threshold = AGING_RST;
            for (int i = 0; i < SLOTS; i++)
                occ[i] = 1'b0;
            sim_clock = '0;
            seq_next  = '0;
            live      = 0;
            errors    = 0;
            result_q.delete();
            pending   = 0;
        end
        else begin
            if (cfg_we) begin
                if (cfg_index == CFG_QUANTUM)
                    quantum = cfg_data[7:0];
                else
                    threshold = cfg_data;
            end
            // result transfer is checked against what was queued before
            if (out_valid && !out_stall) begin
                if (result_q.size() == 0) begin
                    $error("result transfer with nothing expected");
                    errors++;
                end
                else begin
                    e = result_q.pop_front();
                    check_field("status", 32'(e.st), 32'(status));
                    check_field("run_id", 32'(e.id), 32'(run_id));
                    check_field("run_level", 32'(e.lvl), 32'(run_level));
                    check_field("ticks_run", 32'(e.ticks), 32'(ticks_run));
                    check_field("burst_left", 32'(e.left), 32'(burst_left));
                    check_field("finished", 32'(e.fin), 32'(finished));
                    check_field("aged_count", 32'(e.aged), 32'(aged_count));
                    check_field("time_now", e.now, time_now);
                end
            end
            if (in_valid && !in_stall)
                predict_request(req_type, task_id, priority_req, burst);
            pending = result_q.size();
        end
    end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// Top of the scheduler testbench: clock, reset, request stimulus, result
// back-pressure, config phases and the verdict. Depends on mpas_pkg,
// mpas_checker and the multilevel_priority_aging_scheduler_core RTL.
module testbench;
    import mpas_pkg::*;

    localparam int LEVELS   = 10;
    localparam int SLOTS    = 64;
    localparam int WD_LIMIT = 60000;   // well above the longest dispatch
    localparam int LIVE_CAP = 6;       // keeps the dispatch scans short

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        req_type = 1'b0;
    logic [7:0]  task_id = '0;
    logic [3:0]  priority_req = '0;
    logic [15:0] burst = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  status;
    logic [7:0]  run_id;
    logic [3:0]  run_level;
    logic [7:0]  ticks_run;
    logic [15:0] burst_left;
    logic        finished;
    logic [6:0]  aged_count;
    logic [31:0] time_now;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_data = '0;

    int   errors;
    int   pending;
    int   live;
    logic quiet = 1'b0;        // no idling on either side
    logic [7:0] cur_quantum = QUANTUM_RST;
    int   stall_left = 0;
    int   idle_cycles = 0;

    always #1 clk = ~clk;

    multilevel_priority_aging_scheduler_core #(.LEVELS(LEVELS), .SLOTS(SLOTS)) dut (.*);

    mpas_checker #(.LEVELS(LEVELS), .SLOTS(SLOTS)) checker_i (.*);

    // receiver back-pressure in random bursts
    always @(negedge clk)
    begin
        if (quiet) begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else if (stall_left > 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 18);
            out_stall <= 1'b1;
        end
        else begin
            out_stall <= 1'b0;
        end
    end

    // watchdog: cycles in a row with no transfer on either channel
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WD_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // one request transfer; an idle burst may come first
    task automatic send_req(input logic rq, input logic [7:0] id,
                            input logic [3:0] pr, input logic [15:0] bu);
        if (!quiet && $urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 19)) @(negedge clk);
        req_type     = rq;
        task_id      = id;
        priority_req = pr;
        burst        = bu;
        in_valid     = 1'b1;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic drain;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
        drain();
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        if (idx == CFG_QUANTUM)
            cur_quantum = val[7:0];
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic dispatch;
        send_req(1'b1, 8'($urandom), 4'($urandom), 16'($urandom));
    endtask

    // random item: mostly well-formed adds and dispatches, some bad levels
    task automatic rand_item;
        logic [3:0]  pr;
        logic [15:0] bu;
        int          pick;
        if (live >= LIVE_CAP || $urandom_range(0, 99) < 50) begin
            dispatch();
        end
        else begin
            pr = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                             : 4'($urandom_range(1, LEVELS));
            pick = $urandom_range(0, 99);
            if (pick < 85)
                bu = 16'($urandom_range(0, 12));
            else if (pick < 98 || cur_quantum < 100)
                bu = 16'($urandom_range(13, 300));
            else
                bu = 16'($urandom);
            send_req(1'b0, 8'($urandom), pr, bu);
        end
        // sender holds off until the block has caught up
        if ($urandom_range(0, 199) == 0)
            drain();
    endtask

    task automatic rand_phase(input logic [7:0] q, input logic [15:0] thr,
                              input int n);
        write_reg(CFG_QUANTUM, {8'd0, q});
        write_reg(CFG_AGING, thr);
        repeat (n) rand_item();
    endtask

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: default registers
        dispatch();                               // empty table, idle
        send_req(1'b0, 8'd1, 4'd0, 16'd5);        // level zero rejected
        send_req(1'b0, 8'd2, 4'd11, 16'd5);       // just above top level
        send_req(1'b0, 8'd3, 4'd15, 16'hFFFF);
        send_req(1'b0, 8'd0, 4'd1, 16'd0);        // zero burst
        send_req(1'b0, 8'hFF, 4'd10, 16'd7);
        send_req(1'b0, 8'hFF, 4'd10, 16'd2);      // duplicate id
        send_req(1'b0, 8'hA5, 4'd5, 16'd4);
        repeat (8) dispatch();
        write_reg(CFG_QUANTUM, 16'd255);
        write_reg(CFG_AGING, 16'd0);
        send_req(1'b0, 8'h5A, 4'd3, 16'hFFFF);    // longest burst
        send_req(1'b0, 8'h11, 4'd9, 16'd300);
        dispatch();
        dispatch();

        // fill the table, overflow once, then drain it
        write_reg(CFG_AGING, 16'hFFFF);
        for (int i = live; i < SLOTS; i++)
            send_req(1'b0, 8'(i), 4'($urandom_range(1, LEVELS)), 16'd0);
        send_req(1'b0, 8'h77, 4'd2, 16'd1);       // table full
        send_req(1'b0, 8'h78, 4'd12, 16'd1);      // bad level wins over full
        while (live > 0) dispatch();

        // random phases over several register settings
        rand_phase(8'd255, 16'd0, 400);
        rand_phase(8'd1, 16'hFFFF, 400);
        rand_phase(8'd0, 16'd0, 30);              // quantum zero: clock frozen
        rand_phase(8'd7, 16'd5, 400);
        rand_phase(8'd1, 16'd1, 300);
        quiet = 1'b1;
        rand_phase(8'd255, 16'd2, 400);

        drain();
        repeat (100) @(negedge clk);
        if (errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
